// ===== rtl/bpecs_pkg.sv =====
// ----------------------------------------------------------------------------
// bpecs_pkg
// Types, constants and byte classification helpers for the pre-tokenizer
// chunk splitter.
// ----------------------------------------------------------------------------
package bpecs_pkg;

    // output queue sizing
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_PUSH   = 3;

    // character codes
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] LEAD_MIN = 8'hC2;

    // class of the open chunk
    typedef enum logic [2:0] {
        CL_NONE   = 3'd0,
        CL_LETTER = 3'd1,
        CL_DIGIT  = 3'd2,
        CL_OTHER  = 3'd3,
        CL_SPACE  = 3'd4,
        CL_CONTR  = 3'd5
    } cls_t;

    // one byte of lookahead as seen from the head byte
    typedef struct packed {
        logic       pending;  // not yet received
        logic       past;     // beyond the string end
        logic [7:0] value;
    } peek_t;

    // outcome of trying to release one head byte
    typedef struct packed {
        logic       ok;
        logic       ce;
        cls_t       cls;
        logic [1:0] left;
    } res_t;

    // one queued result item
    typedef struct packed {
        logic       last;
        logic       ce;
        logic [7:0] data_byte;
    } out_item_t;

    function automatic cls_t class_of(input logic [7:0] c);
        cls_t r;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c >= LEAD_MIN) begin
            r = CL_LETTER;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = CL_DIGIT;
        end else if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
            r = CL_SPACE;
        end else begin
            r = CL_OTHER;
        end
        return r;
    endfunction

    // continuation bytes that follow a utf-8 lead
    function automatic logic [1:0] utf8_extra(input logic [7:0] c);
        logic [1:0] r;
        if (c < 8'h80) begin
            r = 2'd0;
        end else if ((c & 8'hE0) == 8'hC0) begin
            r = 2'd1;
        end else if ((c & 8'hF0) == 8'hE0) begin
            r = 2'd2;
        end else if ((c & 8'hF8) == 8'hF0) begin
            r = 2'd3;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

    // byte one ahead of the head
    function automatic peek_t peek1(input logic [7:0] b1, input logic e0,
                                    input logic [1:0] m);
        peek_t p;
        p.value   = b1;
        p.past    = e0;
        p.pending = !e0 && (m <= 2'd1);
        return p;
    endfunction

    // byte two ahead of the head
    function automatic peek_t peek2(input logic [7:0] b2, input logic e0, input logic e1,
                                    input logic [1:0] m);
        peek_t p;
        p.value   = b2;
        p.past    = e0 || ((m > 2'd1) && e1);
        p.pending = !p.past && (m <= 2'd2);
        return p;
    endfunction

    // decide chunk_end of the head byte, or report that more bytes are needed
    function automatic res_t resolve(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic e0, input logic e1,
                                     input logic [1:0] m, input cls_t cls_in,
                                     input logic [1:0] left_in);
        res_t       r;
        cls_t       cls;
        logic [1:0] left;
        logic       early;
        logic       fin;
        peek_t      p1;
        peek_t      p2;
        cls       = cls_in;
        left      = left_in;
        early     = 1'b0;
        fin       = 1'b0;
        r.ok      = 1'b1;
        r.ce      = 1'b0;
        p1        = peek1(b1, e0, m);
        p2        = peek2(b2, e0, e1, m);

        if (cls == CL_NONE) begin
            if (b0 == CH_APOS) begin
                // contraction check
                if (p1.pending) begin
                    r.ok = 1'b0;
                end else if (!p1.past && (p1.value == CH_S || p1.value == CH_T ||
                                          p1.value == CH_M || p1.value == CH_D)) begin
                    cls  = CL_CONTR;
                    left = 2'd1;
                end else if (!p1.past && (p1.value == CH_R || p1.value == CH_V ||
                                          p1.value == CH_L)) begin
                    if (p2.pending) begin
                        r.ok = 1'b0;
                    end else if (!p2.past &&
                                 p2.value == ((p1.value == CH_L) ? CH_L : CH_E)) begin
                        cls  = CL_CONTR;
                        left = 2'd2;
                    end
                end
                if (cls == CL_NONE) begin
                    cls = CL_OTHER;
                end
            end else if (b0 == CH_SPACE && !e0) begin
                // leading space joins the next run unless whitespace follows
                if (p1.pending || p1.past) begin
                    r.ok = 1'b0;
                    cls  = CL_SPACE;
                end else begin
                    cls = class_of(p1.value);
                    if (cls != CL_SPACE) begin
                        early = 1'b1;
                        left  = 2'd0;
                    end
                end
            end else begin
                cls = class_of(b0);
            end
            if (!early && cls == CL_LETTER) begin
                left = utf8_extra(b0);
            end
        end else if (cls == CL_LETTER) begin
            if (left != 2'd0) begin
                left = left - 2'd1;
            end else begin
                left = utf8_extra(b0);
            end
        end else if (cls == CL_CONTR) begin
            if (left != 2'd0) begin
                left = left - 2'd1;
            end
        end

        // chunk end decision
        if (!early) begin
            if (e0) begin
                fin = 1'b1;
            end else if (cls == CL_CONTR) begin
                fin = (left == 2'd0);
            end else if (cls == CL_LETTER && left != 2'd0) begin
                fin = 1'b0;
            end else if (p1.pending || p1.past) begin
                r.ok = 1'b0;
            end else begin
                fin = (class_of(p1.value) != cls);
            end
        end

        r.ce   = fin;
        r.cls  = fin ? CL_NONE : cls;
        r.left = fin ? 2'd0 : left;
        return r;
    endfunction

endpackage

// ===== rtl/bpe_pretokenizer_chunk_splitter.sv =====
// ----------------------------------------------------------------------------
// bpe_pretokenizer_chunk_splitter
// Passes a text byte stream through and flags the byte that closes each
// pre-tokenizer chunk (contractions, letter, digit, other and space runs).
// ----------------------------------------------------------------------------
// queueing: a byte whose chunk end is known is written into the output queue
//   as it is taken; a byte may wait for up to two later bytes or a string end
// throughput: one byte per cycle; the eight-entry output queue stops intake
//   while it holds more than five items
// reset: aresetn (synchronous) empties the lookahead and the output queue and
//   closes any open chunk
module bpe_pretokenizer_chunk_splitter
    import bpecs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // string_end
    // marked byte stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] chunk_end
    output logic       m_tlast    // last_of_string
);

    // lookahead and chunk state
    logic [7:0]         look_byte_reg [2];
    logic [7:0]         look_byte_next [2];
    logic [1:0]         held_count_reg, held_count_next;
    cls_t               run_class_reg, run_class_next;
    logic [1:0]         utf8_left_reg, utf8_left_next;

    // output queue
    out_item_t          fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               s_fire;
    logic               m_fire;
    logic [7:0]         q_byte [MAX_PUSH];
    logic               q_end  [MAX_PUSH];
    logic [1:0]         q_count;
    res_t               res    [MAX_PUSH];
    logic               rel    [MAX_PUSH];
    out_item_t          items  [MAX_PUSH];
    logic [1:0]         push_cnt;

    assign s_tready = (count_reg <= CNT_W'(FIFO_DEPTH - MAX_PUSH));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = fifo_mem_reg[rd_ptr_reg].data_byte;
    assign m_tuser  = fifo_mem_reg[rd_ptr_reg].ce;
    assign m_tlast  = fifo_mem_reg[rd_ptr_reg].last;

    // held bytes followed by the incoming byte
    always_comb begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (2'(i) < held_count_reg) begin
                q_byte[i] = look_byte_reg[i % 2];
                q_end[i]  = 1'b0;
            end else if (2'(i) == held_count_reg) begin
                q_byte[i] = s_tdata;
                q_end[i]  = s_tlast;
            end else begin
                q_byte[i] = 8'h00;
                q_end[i]  = 1'b0;
            end
        end
        q_count = held_count_reg + 2'd1;
    end

    // release up to three bytes in order
    always_comb begin
        res[0] = resolve(q_byte[0], q_byte[1], q_byte[2], q_end[0], q_end[1],
                         q_count, run_class_reg, utf8_left_reg);
        rel[0] = res[0].ok;
        res[1] = resolve(q_byte[1], q_byte[2], 8'h00, q_end[1], q_end[2],
                         q_count - 2'd1, res[0].cls, res[0].left);
        rel[1] = rel[0] && (q_count >= 2'd2) && res[1].ok;
        res[2] = resolve(q_byte[2], 8'h00, 8'h00, q_end[2], 1'b0,
                         q_count - 2'd2, res[1].cls, res[1].left);
        rel[2] = rel[1] && (q_count == 2'd3) && res[2].ok;
        push_cnt = 2'(rel[0]) + 2'(rel[1]) + 2'(rel[2]);
        for (int i = 0; i < MAX_PUSH; i++) begin
            items[i].last      = q_end[i];
            items[i].ce        = res[i].ce;
            items[i].data_byte = q_byte[i];
        end
    end

    // next lookahead and chunk state
    always_comb begin
        look_byte_next[0] = look_byte_reg[0];
        look_byte_next[1] = look_byte_reg[1];
        held_count_next   = held_count_reg;
        run_class_next    = run_class_reg;
        utf8_left_next    = utf8_left_reg;
        if (s_fire) begin
            held_count_next = q_count - push_cnt;
            case (push_cnt)
                2'd0: begin
                    look_byte_next[0] = q_byte[0];
                    look_byte_next[1] = q_byte[1];
                end
                2'd1: begin
                    look_byte_next[0] = q_byte[1];
                    look_byte_next[1] = q_byte[2];
                    run_class_next    = res[0].cls;
                    utf8_left_next    = res[0].left;
                end
                2'd2: begin
                    look_byte_next[0] = q_byte[2];
                    run_class_next    = res[1].cls;
                    utf8_left_next    = res[1].left;
                end
                default: begin
                    run_class_next = res[2].cls;
                    utf8_left_next = res[2].left;
                end
            endcase
        end
    end

    // queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (s_fire) begin
            wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
            count_next  = count_next + CNT_W'(push_cnt);
        end
        if (m_fire) begin
            rd_ptr_next = rd_ptr_reg + FIFO_AW'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 2'd0;
            run_class_reg  <= CL_NONE;
            utf8_left_reg  <= 2'd0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            held_count_reg <= held_count_next;
            run_class_reg  <= run_class_next;
            utf8_left_reg  <= utf8_left_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    // lookahead bytes and queue storage
    always_ff @(posedge aclk) begin
        look_byte_reg[0] <= look_byte_next[0];
        look_byte_reg[1] <= look_byte_next[1];
        if (s_fire) begin
            for (int k = 0; k < MAX_PUSH; k++) begin
                if (2'(k) < push_cnt) begin
                    fifo_mem_reg[wr_ptr_reg + FIFO_AW'(k)] <= items[k];
                end
            end
        end
    end

`ifndef SYNTH
    // never more than two undecided bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd3)
        else $error("lookahead holds three bytes");

    // a string end flushes the lookahead
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> held_count_reg == 2'd0 && run_class_reg == CL_NONE)
        else $error("bytes held across a string end");

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    // no owed bytes while no chunk is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_class_reg == CL_NONE |-> utf8_left_reg == 2'd0)
        else $error("owed bytes with no chunk open");
`endif

endmodule

// ===== test/tb_bpe_pretokenizer_chunk_splitter.sv =====
// ----------------------------------------------------------------------------
// tb_bpe_pretokenizer_chunk_splitter
// Self-checking bench for the chunk splitter: text strings go in byte by
// byte, a local chunk predictor or a typed row gives every marked byte, and each byte
// that leaves the block is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_bpe_pretokenizer_chunk_splitter
    import bpecs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int AHEAD_WAIT = -1;
    localparam int AHEAD_PAST = -2;
    localparam int N_DIRECTED = 25;

    // one marked byte as it leaves the block
    typedef struct packed {
        logic [7:0] text_byte;
        logic       chunk_end;
        logic       last;
    } marked_byte_t;

    // directed stimulus row; typed rows carry their known result
    typedef struct packed {
        logic [7:0] text_byte;
        logic       string_end;
        logic       typed;
        logic       exp_ce;
        logic       exp_last;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // predictor state
    marked_byte_t expected_marks[$];
    logic [7:0]   held_bytes[$];
    cls_t         open_class = CL_NONE;
    logic [1:0]   owed_bytes = 2'd0;
    logic [7:0]   win_byte[4];
    logic         win_end[4];
    int           win_n;

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  send_idle_pct = 34;
    int  recv_idle_pct = 46;
    bit  hold_off_req = 1'b0;
    logic [7:0] text_q[$];

    logic [7:0] contr_tail[9] = '{CH_S, CH_T, CH_M, CH_D, CH_R, CH_V, CH_L, CH_E, 8'h78};

    stim_row_t directed_rows[N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1},   // zero byte alone
        '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1},   // top byte alone
        '{CH_APOS, 1'b0, 1'b0, 1'b0, 1'b0}, // 's then 'll
        '{CH_S, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_APOS, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_L, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_L, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CH_APOS, 1'b0, 1'b0, 1'b0, 1'b0}, // broken 've
        '{CH_V, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h78, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CH_SPACE, 1'b0, 1'b0, 1'b0, 1'b0}, // leading space, utf-8 letter, spaces
        '{8'h41, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hC3, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hA9, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_SPACE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CH_SPACE, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h31, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h0A, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hE2, 1'b1, 1'b0, 1'b0, 1'b0},   // lead cut short by string end
        '{CH_APOS, 1'b1, 1'b1, 1'b1, 1'b1}, // lone apostrophe
        '{8'hF0, 1'b0, 1'b0, 1'b0, 1'b0},   // four-byte lead, three bytes given
        '{8'h9F, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h21, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b1, 1'b1},   // stray continuation byte
        '{CH_SPACE, 1'b1, 1'b1, 1'b1, 1'b1} // space closing a string
    };

    bpe_pretokenizer_chunk_splitter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // byte class as the chunk rules see it
    function automatic cls_t byte_class(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= LEAD_MIN || (folded >= 8'h61 && folded <= 8'h7A)) return CL_LETTER;
        if (c >= 8'h30 && c <= 8'h39) return CL_DIGIT;
        if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) return CL_SPACE;
        return CL_OTHER;
    endfunction

    // continuation bytes owed after a lead byte
    function automatic int extra_of(input logic [7:0] c);
        casez (c)
            8'b0???????: return 0;
            8'b110?????: return 1;
            8'b1110????: return 2;
            8'b11110???: return 3;
            default:     return 0;
        endcase
    endfunction

    // byte k ahead of window slot h, stopping at a string end
    function automatic int ahead(input int h, input int k);
        int j;
        for (j = 0; j < k && h + j < win_n; j++) begin
            if (win_end[h + j]) return AHEAD_PAST;
        end
        if (h + k >= win_n) return AHEAD_WAIT;
        return int'(win_byte[h + k]);
    endfunction

    // decide chunk end of the byte in slot h; 0 when more bytes are needed
    function automatic bit decide_head(input int h, output bit ce);
        logic [7:0] c;
        cls_t       cls;
        int         left;
        int         n1;
        int         n2;
        bit         fin;
        c    = win_byte[h];
        cls  = open_class;
        left = owed_bytes;
        ce   = 1'b0;
        if (cls == CL_NONE) begin
            if (c == CH_APOS) begin
                // contraction lookahead
                n1 = ahead(h, 1);
                if (n1 == AHEAD_WAIT) return 1'b0;
                if (n1 == CH_S || n1 == CH_T || n1 == CH_M || n1 == CH_D) begin
                    cls  = CL_CONTR;
                    left = 1;
                end else if (n1 == CH_R || n1 == CH_V || n1 == CH_L) begin
                    n2 = ahead(h, 2);
                    if (n2 == AHEAD_WAIT) return 1'b0;
                    if (n2 == ((n1 == CH_L) ? CH_L : CH_E)) begin
                        cls  = CL_CONTR;
                        left = 2;
                    end
                end
                if (cls == CL_NONE) cls = CL_OTHER;
            end else if (c == CH_SPACE && !win_end[h]) begin
                // space joins the next run unless whitespace follows
                n1 = ahead(h, 1);
                if (n1 < 0) return 1'b0;
                cls = byte_class(n1[7:0]);
                if (cls != CL_SPACE) begin
                    open_class = cls;
                    owed_bytes = 2'd0;
                    return 1'b1;
                end
            end else begin
                cls = byte_class(c);
            end
            if (cls == CL_LETTER) left = extra_of(c);
        end else if (cls == CL_LETTER) begin
            if (left > 0) left--;
            else left = extra_of(c);
        end else if (cls == CL_CONTR) begin
            if (left > 0) left--;
        end

        // chunk end
        if (win_end[h]) begin
            fin = 1'b1;
        end else if (cls == CL_CONTR) begin
            fin = (left == 0);
        end else if (cls == CL_LETTER && left > 0) begin
            fin = 1'b0;
        end else begin
            n1 = ahead(h, 1);
            if (n1 < 0) return 1'b0;
            fin = (byte_class(n1[7:0]) != cls);
        end
        if (fin) begin
            open_class = CL_NONE;
            owed_bytes = 2'd0;
        end else begin
            open_class = cls;
            owed_bytes = 2'(left);
        end
        ce = fin;
        return 1'b1;
    endfunction

    // release every byte whose chunk end is now known
    function automatic void split_byte(input logic [7:0] b, input logic e);
        int h;
        int i;
        bit ce;
        win_n = 0;
        for (i = 0; i < held_bytes.size(); i++) begin
            win_byte[win_n] = held_bytes[i];
            win_end[win_n]  = 1'b0;
            win_n++;
        end
        win_byte[win_n] = b;
        win_end[win_n]  = e;
        win_n++;
        h = 0;
        while (h < win_n && decide_head(h, ce)) begin
            expected_marks.push_back('{win_byte[h], ce, win_end[h]});
            h++;
        end
        held_bytes.delete();
        for (i = h; i < win_n && held_bytes.size() < 3; i++) held_bytes.push_back(win_byte[i]);
    endfunction

    // offer one item and wait for it to be taken
    task automatic offer_byte(input logic [7:0] b, input logic e, input logic typed,
                              input logic exp_ce, input logic exp_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= e;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        if (typed) expected_marks.push_back('{b, exp_ce, exp_last});
        else split_byte(b, e);
        items_sent++;
        @(posedge aclk);
    endtask

    // build one text string, mostly well-formed pieces with some noise
    task automatic compose_text();
        int pieces;
        int p;
        int k;
        int n;
        logic [7:0] lead;
        text_q.delete();
        pieces = $urandom_range(1, 5);
        for (p = 0; p < pieces; p++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // letter run
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++)
                        text_q.push_back(8'(($urandom_range(0, 1) ? 8'h41 : 8'h61)
                                            + $urandom_range(0, 25)));
                end
                2: begin
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++) text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
                end
                3: begin
                    // whitespace run
                    n = $urandom_range(1, 2);
                    for (k = 0; k < n; k++)
                        text_q.push_back($urandom_range(0, 1) ? CH_SPACE
                                                              : 8'(8'h09 + $urandom_range(0, 4)));
                end
                4: begin
                    // contraction, sometimes broken
                    k = $urandom_range(0, 8);
                    text_q.push_back(CH_APOS);
                    text_q.push_back(contr_tail[k]);
                    if (contr_tail[k] == CH_R || contr_tail[k] == CH_V || contr_tail[k] == CH_L) begin
                        if ($urandom_range(0, 9) < 7)
                            text_q.push_back((contr_tail[k] == CH_L) ? CH_L : CH_E);
                        else
                            text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
                    end
                end
                5: begin
                    // utf-8 letter with its continuation bytes
                    lead = 8'($urandom_range(8'hC2, 8'hFF));
                    text_q.push_back(lead);
                    n = extra_of(lead);
                    for (k = 0; k < n; k++) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                6: begin
                    text_q.push_back(CH_SPACE);
                    text_q.push_back($urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 25))
                                                          : 8'(8'h30 + $urandom_range(0, 9)));
                end
                7: text_q.push_back(8'(8'h21 + $urandom_range(0, 14)));
                default: begin
                    // raw noise
                    n = $urandom_range(1, 2);
                    for (k = 0; k < n; k++) text_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // send random strings until the item count reaches a mark
    task automatic send_text_until(input int mark);
        int k;
        while (items_sent < mark) begin
            compose_text();
            for (k = 0; k < text_q.size(); k++)
                offer_byte(text_q[k], k == text_q.size() - 1, 1'b0, 1'b0, 1'b0);
        end
    endtask

    // receiver with random stalls and one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // compare each item taken from the block with the oldest expectation
    always @(negedge aclk) begin
        marked_byte_t want;
        marked_byte_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser, m_tlast};
            if (expected_marks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: byte %h chunk_end %b last %b",
                             got.text_byte, got.chunk_end, got.last);
            end else begin
                want = expected_marks.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected byte %h ce %b last %b, got byte %h ce %b last %b",
                                 want.text_byte, want.chunk_end, want.last,
                                 got.text_byte, got.chunk_end, got.last);
                end
            end
        end
    end

    // main sequence
    initial begin
        int r;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed strings
        for (r = 0; r < N_DIRECTED; r++)
            offer_byte(directed_rows[r].text_byte, directed_rows[r].string_end,
                       directed_rows[r].typed, directed_rows[r].exp_ce,
                       directed_rows[r].exp_last);

        // random strings, sender idles less than receiver
        send_text_until(160);

        // receiver idles less than sender
        send_idle_pct = 46;
        recv_idle_pct = 34;
        send_text_until(300);

        // full rate with one long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1'b1;
        send_text_until(405);
        s_tvalid <= 1'b0;

        // drain
        while (expected_marks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_marks.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpecs_pkg.sv
rtl/bpe_pretokenizer_chunk_splitter.sv
test/tb_bpe_pretokenizer_chunk_splitter.sv
